FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared widths, character codes, command codes and the control/status
// structures passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        DP_NOP   = 3'd0,
        DP_LATCH = 3'd1,
        DP_EXEC  = 3'd2,
        DP_COPY  = 3'd3,
        DP_FILL  = 3'd4,
        DP_OUT   = 3'd5
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   fill_reset;
    } t_dp_cmd;

    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic scroll_needed;
        logic copy_done;
        logic fill_last;
    } t_dp_status;

endpackage

FILE: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console writer channel interfaces
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CMD_W-1:0]   command;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::INDEX_W-1:0] cell_index;

    modport source (output valid, output command, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input command, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::INDEX_W-1:0] cursor_position;
    logic [tcw_pkg::CHAR_W-1:0]  cell_char;
    logic [tcw_pkg::ATTR_W-1:0]  cell_attr;
    logic                        scrolled;

    modport source (output valid, output cursor_position, output cell_char,
                    output cell_attr, output scrolled, input ready);
    modport sink (input valid, input cursor_position, input cell_char,
                  input cell_attr, input scrolled, output ready);
endinterface

FILE: rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences one command at a time: latch, execute, store sweeps, result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd    o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid;
        o_cmd.op         = DP_NOP;
        o_cmd.fill_reset = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_INIT: begin
                // Power-up sweep writes the reset blank, not the live attribute.
                o_cmd.op         = DP_FILL;
                o_cmd.fill_reset = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LATCH;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.op = DP_EXEC;
                if (i_status.is_put && i_status.scroll_needed) begin
                    n_state = ST_SCROLL;
                end else if (i_status.is_clear) begin
                    n_state = ST_FILL;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCROLL: begin
                o_cmd.op = DP_COPY;
                if (i_status.copy_done) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.op = DP_FILL;
                if (i_status.fill_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/tcw_dpath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Character and attribute stores, cursor, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcw_dpath #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcw_pkg::t_dp_cmd            i_cmd,
    output tcw_pkg::t_dp_status         o_status,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata,
    input  logic [tcw_pkg::CMD_W-1:0]   i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0] i_cell_index,
    output logic [tcw_pkg::INDEX_W-1:0] o_cursor_position,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_cell_attr,
    output logic                        o_scrolled
);
    import tcw_pkg::*;

    localparam int TEXT_ROWS  = SCREEN_ROWS - 1;
    localparam int CELL_COUNT = SCREEN_COLUMNS * TEXT_ROWS;
    localparam int COPY_COUNT = CELL_COUNT - SCREEN_COLUMNS;
    localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CW         = $clog2(SCREEN_COLUMNS);
    localparam int RW         = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

    // Stores, one byte lane each so a backspace can clear the character only.
    logic [CHAR_W-1:0] r_char_mem [CELL_COUNT];
    logic [ATTR_W-1:0] r_attr_mem [CELL_COUNT];
    logic [CHAR_W-1:0] r_rd_char;
    logic [ATTR_W-1:0] r_rd_attr;

    logic [ATTR_W-1:0]  r_attr;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [AW-1:0]      r_cnt;
    logic               r_wr_pend;
    logic [AW-1:0]      r_wr_addr;
    logic [CMD_W-1:0]   r_cmd;
    logic [CHAR_W-1:0]  r_char;
    logic [INDEX_W-1:0] r_index;
    logic               r_scrolled;
    logic [INDEX_W-1:0] r_out_pos;
    logic [CHAR_W-1:0]  r_out_char;
    logic [ATTR_W-1:0]  r_out_attr;
    logic               r_out_scrolled;

    logic [AW-1:0]     w_pos;
    logic [CW:0]       w_col_inc;
    logic [RW:0]       w_row_inc;
    logic              w_col_wrap;
    logic              w_is_nl;
    logic              w_is_bs;
    logic              w_row_adv;
    logic              w_scroll;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic              w_is_put;
    logic              w_is_clear;
    logic              w_is_read;
    logic              w_index_ok;
    logic              w_copy_end;
    logic              w_fill_last;
    logic              w_char_we;
    logic              w_attr_we;
    logic [AW-1:0]     w_wr_addr;
    logic [CHAR_W-1:0] w_wr_char;
    logic [ATTR_W-1:0] w_wr_attr;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;

    assign w_pos      = AW'(int'(r_row) * SCREEN_COLUMNS + int'(r_col));
    assign w_col_inc  = {1'b0, r_col} + 1'b1;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_col_wrap = (w_col_inc == (CW+1)'(SCREEN_COLUMNS));
    assign w_is_nl    = (r_char == CH_NEWLINE);
    assign w_is_bs    = (r_char == CH_BACKSPACE);
    assign w_row_adv  = w_is_nl || (!w_is_bs && w_col_wrap);
    assign w_scroll   = w_row_adv && (w_row_inc == (RW+1)'(TEXT_ROWS));
    assign w_is_put   = (r_cmd == CMD_PUT);
    assign w_is_clear = (r_cmd == CMD_CLEAR);
    assign w_is_read  = (r_cmd == CMD_READ);
    assign w_index_ok = (int'(r_index) < CELL_COUNT);
    assign w_copy_end = (r_cnt == AW'(COPY_COUNT));
    assign w_fill_last = (r_cnt == AW'(CELL_COUNT - 1));

    always_comb begin
        if (w_is_nl) begin
            n_col = '0;
        end else if (w_is_bs) begin
            n_col = (r_col != '0) ? r_col - 1'b1 : r_col;
        end else begin
            n_col = w_col_wrap ? '0 : w_col_inc[CW-1:0];
        end
        if (!w_row_adv) begin
            n_row = r_row;
        end else if (w_scroll) begin
            n_row = RW'(TEXT_ROWS - 1);
        end else begin
            n_row = w_row_inc[RW-1:0];
        end
    end

    // Single write port and single read port for each store.
    always_comb begin
        w_char_we = 1'b0;
        w_attr_we = 1'b0;
        w_wr_addr = w_pos;
        w_wr_char = r_char;
        w_wr_attr = r_attr;
        w_rd_en   = 1'b0;
        w_rd_addr = AW'(r_index);
        case (i_cmd.op)
            DP_EXEC: begin
                if (w_is_put) begin
                    if (w_is_bs) begin
                        if (r_col != '0) begin
                            w_char_we = 1'b1;
                            w_wr_addr = w_pos - 1'b1;
                            w_wr_char = '0;
                        end
                    end else if (!w_is_nl) begin
                        w_char_we = 1'b1;
                        w_attr_we = 1'b1;
                    end
                end
                w_rd_en = w_is_read && w_index_ok;
            end
            DP_COPY: begin
                // Reads run one cell ahead of the write-back of the row below.
                w_char_we = r_wr_pend;
                w_attr_we = r_wr_pend;
                w_wr_addr = r_wr_addr;
                w_wr_char = r_rd_char;
                w_wr_attr = r_rd_attr;
                w_rd_en   = !w_copy_end;
                w_rd_addr = AW'(int'(r_cnt) + SCREEN_COLUMNS);
            end
            DP_FILL: begin
                w_char_we = 1'b1;
                w_attr_we = 1'b1;
                w_wr_addr = r_cnt;
                w_wr_char = '0;
                w_wr_attr = i_cmd.fill_reset ? ATTR_RESET : r_attr;
            end
            default: begin
                w_char_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_char_we) begin
            r_char_mem[w_wr_addr] <= w_wr_char;
        end
        if (w_rd_en) begin
            r_rd_char <= r_char_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_attr_we) begin
            r_attr_mem[w_wr_addr] <= w_wr_attr;
        end
        if (w_rd_en) begin
            r_rd_attr <= r_attr_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= ATTR_RESET;
            r_col     <= '0;
            r_row     <= '0;
            r_cnt     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            case (i_cmd.op)
                DP_EXEC: begin
                    if (w_is_put) begin
                        r_col <= n_col;
                        r_row <= n_row;
                    end else if (w_is_clear) begin
                        r_col <= '0;
                        r_row <= '0;
                    end
                    r_cnt     <= '0;
                    r_wr_pend <= 1'b0;
                end
                DP_COPY: begin
                    if (!w_copy_end) begin
                        r_cnt     <= r_cnt + 1'b1;
                        r_wr_pend <= 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                    end
                end
                DP_FILL: begin
                    if (!w_fill_last) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_wr_pend <= r_wr_pend;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_cmd   <= i_command;
                r_char  <= i_char_code;
                r_index <= i_cell_index;
            end
            DP_EXEC: begin
                r_scrolled <= w_is_put && w_scroll;
            end
            DP_COPY: begin
                r_wr_addr <= r_cnt;
            end
            DP_OUT: begin
                r_out_pos      <= INDEX_W'(w_pos);
                r_out_char     <= (w_is_read && w_index_ok) ? r_rd_char : '0;
                r_out_attr     <= (w_is_read && w_index_ok) ? r_rd_attr : '0;
                r_out_scrolled <= r_scrolled;
            end
            default: begin
                r_out_pos <= r_out_pos;
            end
        endcase
    end

    assign o_status.is_put        = w_is_put;
    assign o_status.is_clear      = w_is_clear;
    assign o_status.scroll_needed = w_scroll;
    assign o_status.copy_done     = w_copy_end && !r_wr_pend;
    assign o_status.fill_last     = w_fill_last;

    assign o_cursor_position = r_out_pos;
    assign o_cell_char       = r_out_char;
    assign o_cell_attr       = r_out_attr;
    assign o_scrolled        = r_out_scrolled;

endmodule

FILE: rtl/text_console_writer_unit.sv
// A put without scroll, a read or an unused command goes through the execute
// and finish states to its registered result beat. A new command is taken
// only back in idle, after that beat is issued; finish waits while an earlier
// result beat is stalled. A clear sweeps the store one cell a cycle. A scrolling
// put copies one cell a cycle through each store's read and write ports, then
// blanks the last row. After reset the store is blanked with the reset attribute.
// ----------------------------------------------------------------------------
// Text console writer top level
// Character console over a character/attribute store with scroll and clear.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcw_in_if.sink                     i_in_bus,
    tcw_out_if.source                  o_out_bus,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata
);
    import tcw_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_bus.valid),
        .o_in_ready  (i_in_bus.ready),
        .i_out_ready (o_out_bus.ready),
        .o_out_valid (o_out_bus.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tcw_dpath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_command         (i_in_bus.command),
        .i_char_code       (i_in_bus.char_code),
        .i_cell_index      (i_in_bus.cell_index),
        .o_cursor_position (o_out_bus.cursor_position),
        .o_cell_char       (o_out_bus.cell_char),
        .o_cell_attr       (o_out_bus.cell_attr),
        .o_scrolled        (o_out_bus.scrolled)
    );

endmodule

FILE: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer port checker
// Checks result beats and the one-item-at-a-time behavior seen at the ports.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tcw_pkg::INDEX_W-1:0] i_cursor_position,
    input logic [tcw_pkg::CHAR_W-1:0]  i_cell_char,
    input logic [tcw_pkg::ATTR_W-1:0]  i_cell_attr,
    input logic                        i_scrolled
);
    import tcw_pkg::*;

    localparam int TEXT_ROWS  = SCREEN_ROWS - 1;
    localparam int CELL_COUNT = SCREEN_COLUMNS * TEXT_ROWS;
    localparam int LAST_ROW   = (TEXT_ROWS - 1) * SCREEN_COLUMNS;
    localparam bit POS_FITS   = (CELL_COUNT <= 2048);

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cursor_position)
            && $stable(i_cell_char) && $stable(i_cell_attr) && $stable(i_scrolled))
        else $error("result beat changed while stalled");

    // Items are worked one at a time, so the input closes right after a beat.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted again while an item is in work");

    // The cursor never leaves the text area.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && POS_FITS |-> int'(i_cursor_position) < CELL_COUNT)
        else $error("cursor position beyond the text area");

    // A scroll leaves the cursor on the last text row.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_scrolled && POS_FITS |-> int'(i_cursor_position) >= LAST_ROW)
        else $error("scroll reported with cursor above the last row");

    // Reset empties the output and holds off input for the store blanking.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("activity on the ports right after reset");

endmodule

bind text_console_writer_unit tcw_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_bus.valid),
    .i_in_ready        (i_in_bus.ready),
    .i_out_valid       (o_out_bus.valid),
    .i_out_ready       (o_out_bus.ready),
    .i_cursor_position (o_out_bus.cursor_position),
    .i_cell_char       (o_out_bus.cell_char),
    .i_cell_attr       (o_out_bus.cell_attr),
    .i_scrolled        (o_out_bus.scrolled)
);
